// ===== rtl/framed_hex_key_parser_defines.svh =====
// Assertion macros for the framed hex key parser.
`ifndef FRAMED_HEX_KEY_PARSER_DEFINES_SVH
`define FRAMED_HEX_KEY_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FHKP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define FHKP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fhkp_pkg.sv =====
// Shared types, constants, pattern tables and character helpers of the key parser.
package fhkp_pkg;

	localparam int KEY_STORE_BYTES_DEF = 256;
	localparam int ONE_KEY_BYTES_DEF   = 128;
	localparam int HEAD_LEN            = 37;
	localparam int FOOT_LEN            = 35;
	localparam int PADDR_W             = 3;

	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_SP    = 8'h20;
	localparam logic [7:0] CHAR_HT    = 8'h09;
	localparam logic [7:0] CHAR_VT    = 8'h0B;
	localparam logic [7:0] CHAR_FF    = 8'h0C;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF    = 8'h66;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [1:0] ST_NO_KEY   = 2'd2;
	localparam logic [1:0] ST_NO_FOOT  = 2'd3;

	localparam logic REG_MUST_SUCCEED = 1'b0;

	localparam logic [7:0] HEAD_ROM [HEAD_LEN] = '{
		8'h2D, 8'h2D, 8'h2D, 8'h2D, 8'h2D, 8'h42, 8'h45, 8'h47, 8'h49, 8'h4E,
		8'h20, 8'h4F, 8'h70, 8'h65, 8'h6E, 8'h56, 8'h50, 8'h4E, 8'h20, 8'h53,
		8'h74, 8'h61, 8'h74, 8'h69, 8'h63, 8'h20, 8'h6B, 8'h65, 8'h79, 8'h20,
		8'h56, 8'h31, 8'h2D, 8'h2D, 8'h2D, 8'h2D, 8'h2D
	};

	localparam logic [7:0] FOOT_ROM [FOOT_LEN] = '{
		8'h2D, 8'h2D, 8'h2D, 8'h2D, 8'h2D, 8'h45, 8'h4E, 8'h44, 8'h20, 8'h4F,
		8'h70, 8'h65, 8'h6E, 8'h56, 8'h50, 8'h4E, 8'h20, 8'h53, 8'h74, 8'h61,
		8'h74, 8'h69, 8'h63, 8'h20, 8'h6B, 8'h65, 8'h79, 8'h20, 8'h56, 8'h31,
		8'h2D, 8'h2D, 8'h2D, 8'h2D, 8'h2D
	};

	typedef struct packed {
		logic [7:0] char_in;
		logic       last;
	} char_item_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  key_byte;
		logic [7:0]  byte_index;
		logic        done_res;
		logic [1:0]  keys_found;
		logic        footer_seen;
		logic [1:0]  status;
		logic [15:0] error_line;
	} res_item_t;

	function automatic logic [7:0] head_char(input logic [5:0] idx);
		logic [7:0] ch;
		ch = '0;
		if (32'(idx) < HEAD_LEN) begin
			ch = HEAD_ROM[idx];
		end
		return ch;
	endfunction

	function automatic logic [7:0] foot_char(input logic [5:0] idx);
		logic [7:0] ch;
		ch = '0;
		if (32'(idx) < FOOT_LEN) begin
			ch = FOOT_ROM[idx];
		end
		return ch;
	endfunction

	// {is_hex, nibble}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] hv;
		hv = '0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			hv = {1'b1, 4'(c - CHAR_ZERO)};
		end else if (c >= CHAR_LA && c <= CHAR_LF) begin
			hv = {1'b1, 4'(c - CHAR_LA + 8'd10)};
		end else if (c >= CHAR_UA && c <= CHAR_UF) begin
			hv = {1'b1, 4'(c - CHAR_UA + 8'd10)};
		end
		return hv;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CHAR_SP || c == CHAR_HT || c == CHAR_VT || c == CHAR_FF ||
			c == CHAR_CR || c == CHAR_NL;
	endfunction

endpackage

// ===== rtl/framed_hex_key_parser.sv =====
// Top level of the framed hex key parser: input register, result register, register port.
//
// Usage: one text character per transaction on the char channel (char_valid, char_stall,
// char_item). Every accepted character yields exactly one result transaction on the res
// channel (res_valid, res_stall, res_item), in order. A result carries a decoded key byte
// and its index when a hex pair completes; the result for the character marked last also
// carries the key count, footer flag, status and error line, after which the parser
// rearms for a new text.
// An accepted character passes through the input register and then the result register before it appears as a result.
// Throughput: one character per cycle while the receiver does not stall, set by the combinational
// state update between the input register and the result register.
// When the receiver stalls, the result register holds its transaction, one more character
// waits in the input register, and char_stall then rises until the result is taken.
// Reset returns the parser state to its start, clears the valid flags of both registers and sets must_succeed to 0.
// must_succeed is at byte address 0 of the register port; write it only while idle.
`include "framed_hex_key_parser_defines.svh"

module framed_hex_key_parser #(
	parameter int KEY_STORE_BYTES = fhkp_pkg::KEY_STORE_BYTES_DEF,
	parameter int ONE_KEY_BYTES   = fhkp_pkg::ONE_KEY_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          char_valid,
	output logic                          char_stall,
	input  fhkp_pkg::char_item_t          char_item,
	output logic                          res_valid,
	input  logic                          res_stall,
	output fhkp_pkg::res_item_t           res_item,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fhkp_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	fhkp_pkg::char_item_t item_s1;
	logic                 valid_s1;
	fhkp_pkg::res_item_t  res_n;
	fhkp_pkg::res_item_t  res_s2;
	logic                 valid_s2;
	logic                 must_succeed_q;
	logic                 advance;
	logic                 accept;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == fhkp_pkg::REG_MUST_SUCCEED) ? {31'd0, must_succeed_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			must_succeed_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == fhkp_pkg::REG_MUST_SUCCEED) begin
			must_succeed_q <= pwdata[0];
		end
	end

	assign advance    = valid_s1 && (!valid_s2 || !res_stall);
	assign char_stall = valid_s1 && !advance;
	assign accept     = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= char_item;
		end
	end

	fhkp_parse #(
		.KEY_STORE_BYTES(KEY_STORE_BYTES),
		.ONE_KEY_BYTES  (ONE_KEY_BYTES)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.item        (item_s1),
		.must_succeed(must_succeed_q),
		.res         (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_n;
		end
	end

	assign res_valid = valid_s2;
	assign res_item  = res_s2;

	`FHKP_ASSERT_NEXT(a_advance_loads, advance, valid_s2, "result register not loaded")
	`FHKP_ASSERT_IMPLY(a_idle_byte_zero, valid_s2 && !res_s2.byte_valid, res_s2.key_byte == 8'd0 && res_s2.byte_index == 8'd0, "byte fields set without byte")
	`FHKP_ASSERT_IMPLY(a_summary_zero, valid_s2 && !res_s2.done_res, res_s2.keys_found == 2'd0 && res_s2.status == fhkp_pkg::ST_OK && !res_s2.footer_seen && res_s2.error_line == 16'd0, "summary set before end")
	`FHKP_ASSERT_IMPLY(a_bad_line, valid_s2 && res_s2.done_res && res_s2.status == fhkp_pkg::ST_BAD_CHAR, res_s2.error_line != 16'd0, "bad character without line")

endmodule

// ===== rtl/fhkp_parse.sv =====
// Parser state and single-pass per-character update producing one result transaction.
module fhkp_parse #(
	parameter int KEY_STORE_BYTES = fhkp_pkg::KEY_STORE_BYTES_DEF,
	parameter int ONE_KEY_BYTES   = fhkp_pkg::ONE_KEY_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  fhkp_pkg::char_item_t   item,
	input  logic                   must_succeed,
	output fhkp_pkg::res_item_t    res
);

	localparam int BCW = $clog2(KEY_STORE_BYTES + 1);
	localparam int K1  = ONE_KEY_BYTES;
	localparam int K2  = 2 * ONE_KEY_BYTES;
	localparam int K3  = 3 * ONE_KEY_BYTES;

	typedef enum logic [2:0] {
		PH_SEEK, PH_HEAD, PH_DATA, PH_FULL, PH_FOOT, PH_DONE
	} phase_t;

	phase_t          phase_q, phase_n;
	logic [7:0]      col_q, col_n;
	logic [5:0]      mc_q, mc_n;
	logic [3:0]      hn_q, hn_n;
	logic            np_q, np_n;
	logic [BCW-1:0]  bc_q, bc_n;
	logic [15:0]     line_q, line_n;
	logic [15:0]     bad_q, bad_n;
	logic [4:0]      hv;
	logic [7:0]      c;

	always_comb begin
		phase_n = phase_q;
		col_n   = col_q;
		mc_n    = mc_q;
		hn_n    = hn_q;
		np_n    = np_q;
		bc_n    = bc_q;
		line_n  = line_q;
		bad_n   = bad_q;
		res     = '0;
		c       = item.char_in;
		hv      = fhkp_pkg::hex_value(c);

		if (c == fhkp_pkg::CHAR_NL) begin
			col_n = '0;
			mc_n  = '0;
			if (line_q != 16'hFFFF) begin
				line_n = line_q + 16'd1;
			end
		end else begin
			if (col_q == 8'd0) begin
				if (phase_n == PH_HEAD) begin
					phase_n = PH_DATA;
				end
				if ((phase_n == PH_DATA || phase_n == PH_FULL) && c == fhkp_pkg::CHAR_DASH) begin
					phase_n = PH_FOOT;
				end
			end
			if (phase_n == PH_SEEK && 32'(col_q) < fhkp_pkg::HEAD_LEN &&
				c == fhkp_pkg::head_char(col_q[5:0])) begin
				if (mc_q != 6'h3F) begin
					mc_n = mc_q + 6'd1;
				end
				if (32'(mc_n) == fhkp_pkg::HEAD_LEN) begin
					phase_n = PH_HEAD;
				end
			end
			if (phase_n == PH_FOOT && 32'(col_q) < fhkp_pkg::FOOT_LEN &&
				c == fhkp_pkg::foot_char(col_q[5:0])) begin
				if (mc_q != 6'h3F) begin
					mc_n = mc_q + 6'd1;
				end
				if (32'(mc_n) == fhkp_pkg::FOOT_LEN) begin
					phase_n = PH_DONE;
				end
			end
			if (phase_n == PH_DATA) begin
				if (hv[4]) begin
					if (!np_q) begin
						hn_n = hv[3:0];
						np_n = 1'b1;
					end else begin
						np_n           = 1'b0;
						res.byte_valid = 1'b1;
						res.key_byte   = {hn_q, hv[3:0]};
						res.byte_index = 8'(bc_q);
						hn_n           = '0;
						if (32'(bc_q) < KEY_STORE_BYTES) begin
							bc_n = bc_q + BCW'(1);
						end
						if (32'(bc_n) >= KEY_STORE_BYTES) begin
							phase_n = PH_FULL;
						end
					end
				end else if (!fhkp_pkg::is_blank(c)) begin
					if (bad_q == 16'd0) begin
						bad_n = line_q;
					end
				end
			end
			if (col_q != 8'hFF) begin
				col_n = col_q + 8'd1;
			end
		end

		if (item.last) begin
			res.done_res    = 1'b1;
			res.footer_seen = (phase_n == PH_DONE);
			res.error_line  = bad_n;
			priority if (32'(bc_n) >= K3) begin
				res.keys_found = 2'd3;
			end else if (32'(bc_n) >= K2) begin
				res.keys_found = 2'd2;
			end else if (32'(bc_n) >= K1) begin
				res.keys_found = 2'd1;
			end else begin
				res.keys_found = 2'd0;
			end
			priority if (bad_n != 16'd0) begin
				res.status = fhkp_pkg::ST_BAD_CHAR;
			end else if (must_succeed && res.keys_found == 2'd0) begin
				res.status = fhkp_pkg::ST_NO_KEY;
			end else if (must_succeed && phase_n != PH_DONE) begin
				res.status = fhkp_pkg::ST_NO_FOOT;
			end else begin
				res.status = fhkp_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			col_q   <= '0;
			mc_q    <= '0;
			hn_q    <= '0;
			np_q    <= 1'b0;
			bc_q    <= '0;
			line_q  <= 16'd1;
			bad_q   <= '0;
		end else if (fire) begin
			if (item.last) begin
				phase_q <= PH_SEEK;
				col_q   <= '0;
				mc_q    <= '0;
				hn_q    <= '0;
				np_q    <= 1'b0;
				bc_q    <= '0;
				line_q  <= 16'd1;
				bad_q   <= '0;
			end else begin
				phase_q <= phase_n;
				col_q   <= col_n;
				mc_q    <= mc_n;
				hn_q    <= hn_n;
				np_q    <= np_n;
				bc_q    <= bc_n;
				line_q  <= line_n;
				bad_q   <= bad_n;
			end
		end
	end

endmodule

// ===== tb/sv/framed_hex_key_parser_tb.sv =====
// Self-checking testbench for framed_hex_key_parser: directed framing cases plus random key texts.
module framed_hex_key_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		P_SEEK,
		P_HEADER,
		P_DATA,
		P_FULL,
		P_FOOTER,
		P_DONE
	} parse_phase_t;

	localparam int STORE_BYTES = fhkp_pkg::KEY_STORE_BYTES_DEF;
	localparam int KEY_BYTES   = fhkp_pkg::ONE_KEY_BYTES_DEF;
	localparam int RANDOM_ITEMS = 50;
	localparam logic [7:0] BLANKS [5] = '{fhkp_pkg::CHAR_SP, fhkp_pkg::CHAR_HT,
		fhkp_pkg::CHAR_VT, fhkp_pkg::CHAR_FF, fhkp_pkg::CHAR_CR};

	logic                          clk;
	logic                          arst_n;
	logic                          char_valid;
	logic                          char_stall;
	fhkp_pkg::char_item_t          char_item;
	logic                          res_valid;
	logic                          res_stall;
	fhkp_pkg::res_item_t           res_item;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [fhkp_pkg::PADDR_W-1:0]  paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;

	// Parser shadow state
	parse_phase_t phase;
	logic [7:0]   col;
	logic [5:0]   hits;
	logic [3:0]   hi_nib;
	logic         nib_waiting;
	logic [8:0]   nbytes;
	logic [15:0]  line_no;
	logic [15:0]  bad_line;
	logic         must_succeed_q;

	fhkp_pkg::res_item_t expected_res[$];
	logic [7:0]          text_q[$];

	int errors;
	int items_sent;
	int results_seen;
	int texts_sent;
	int bytes_decoded;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;

	framed_hex_key_parser u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	function void clear_parse();
		phase       = P_SEEK;
		col         = '0;
		hits        = '0;
		hi_nib      = '0;
		nib_waiting = 1'b0;
		nbytes      = '0;
		line_no     = 16'd1;
		bad_line    = '0;
	endfunction

	function automatic fhkp_pkg::res_item_t parse_char(input logic [7:0] ch, input logic fin);
		fhkp_pkg::res_item_t r;
		logic [7:0] lc;
		logic       is_digit;
		logic [3:0] nib;
		logic [1:0] keys;
		r  = '0;
		lc = ch | 8'h20;
		nib = '0;
		if (ch == fhkp_pkg::CHAR_NL) begin
			col  = '0;
			hits = '0;
			if (line_no != 16'hFFFF)
				line_no++;
		end else begin
			if (col == 0) begin
				if (phase == P_HEADER)
					phase = P_DATA;
				if ((phase == P_DATA || phase == P_FULL) && ch == fhkp_pkg::CHAR_DASH)
					phase = P_FOOTER;
			end
			if (phase == P_SEEK && col < fhkp_pkg::HEAD_LEN) begin
				if (ch == fhkp_pkg::HEAD_ROM[col]) begin
					if (hits != 6'h3F)
						hits++;
					if (hits == fhkp_pkg::HEAD_LEN)
						phase = P_HEADER;
				end
			end
			if (phase == P_FOOTER && col < fhkp_pkg::FOOT_LEN) begin
				if (ch == fhkp_pkg::FOOT_ROM[col]) begin
					if (hits != 6'h3F)
						hits++;
					if (hits == fhkp_pkg::FOOT_LEN)
						phase = P_DONE;
				end
			end
			if (phase == P_DATA) begin
				is_digit = 1'b1;
				if (ch >= "0" && ch <= "9")
					nib = ch[3:0];
				else if (lc >= "a" && lc <= "f")
					nib = lc[3:0] + 4'd9;
				else
					is_digit = 1'b0;
				if (is_digit) begin
					if (!nib_waiting) begin
						hi_nib      = nib;
						nib_waiting = 1'b1;
					end else begin
						nib_waiting  = 1'b0;
						r.byte_valid = 1'b1;
						r.key_byte   = {hi_nib, nib};
						r.byte_index = nbytes[7:0];
						hi_nib       = '0;
						bytes_decoded++;
						if (nbytes < STORE_BYTES)
							nbytes++;
						if (nbytes >= STORE_BYTES)
							phase = P_FULL;
					end
				end else if (!(ch inside {fhkp_pkg::CHAR_SP, fhkp_pkg::CHAR_HT,
					fhkp_pkg::CHAR_VT, fhkp_pkg::CHAR_FF, fhkp_pkg::CHAR_CR})) begin
					if (bad_line == 0)
						bad_line = line_no;
				end
			end
			if (col != 8'hFF)
				col++;
		end
		if (fin) begin
			keys          = (nbytes / KEY_BYTES > 3) ? 2'd3 : 2'(nbytes / KEY_BYTES);
			r.done_res    = 1'b1;
			r.keys_found  = keys;
			r.footer_seen = (phase == P_DONE);
			if (bad_line != 0)
				r.status = fhkp_pkg::ST_BAD_CHAR;
			else if (must_succeed_q && keys == 0)
				r.status = fhkp_pkg::ST_NO_KEY;
			else if (must_succeed_q && phase != P_DONE)
				r.status = fhkp_pkg::ST_NO_FOOT;
			else
				r.status = fhkp_pkg::ST_OK;
			r.error_line = bad_line;
			clear_parse();
		end
		return r;
	endfunction

	function void check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	task automatic check_result(input fhkp_pkg::res_item_t got);
		fhkp_pkg::res_item_t want;
		if (expected_res.size() == 0) begin
			errors++;
			$display("%0t ns: unexpected result, expected none, actual %p", $time, got);
		end else begin
			want = expected_res.pop_front();
			results_seen++;
			check_field("byte_valid", want.byte_valid, got.byte_valid);
			check_field("key_byte", want.key_byte, got.key_byte);
			check_field("byte_index", want.byte_index, got.byte_index);
			check_field("done_res", want.done_res, got.done_res);
			check_field("keys_found", want.keys_found, got.keys_found);
			check_field("footer_seen", want.footer_seen, got.footer_seen);
			check_field("status", want.status, got.status);
			check_field("error_line", want.error_line, got.error_line);
		end
	endtask

	// Result side: stall at random or for a requested hold-off, check each transaction
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= ($urandom_range(99) < recv_stall_pct);
			end
			@(negedge clk);
			if (arst_n && res_valid && !res_stall)
				check_result(res_item);
		end
	end

	task automatic send_char(input logic [7:0] ch, input logic fin);
		logic acc;
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_item  <= '{char_in: ch, last: fin};
		do begin
			@(negedge clk);
			acc = char_valid && !char_stall;
			@(posedge clk);
		end while (!acc);
		expected_res.push_back(parse_char(ch, fin));
		items_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_char(text_q[i], i == text_q.size() - 1);
		texts_sent++;
		text_q.delete();
	endtask

	task automatic wait_idle();
		char_valid <= 1'b0;
		while (expected_res.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_must_succeed(input logic v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= fhkp_pkg::PADDR_W'(4 * fhkp_pkg::REG_MUST_SUCCEED);
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		must_succeed_q = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		check_field("must_succeed readback", 32'(v), prdata);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function void push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	// Header or footer line; flip one bit at flip_at unless it is negative
	function void push_frame(input logic head_sel, input int flip_at);
		logic [7:0] c;
		int n;
		n = head_sel ? fhkp_pkg::HEAD_LEN : fhkp_pkg::FOOT_LEN;
		for (int i = 0; i < n; i++) begin
			if (head_sel)
				c = fhkp_pkg::HEAD_ROM[i];
			else
				c = fhkp_pkg::FOOT_ROM[i];
			if (i == flip_at)
				c ^= 8'h01;
			text_q.push_back(c);
		end
	endfunction

	function logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10)
			return 8'(fhkp_pkg::CHAR_ZERO + v);
		return 8'(($urandom_range(1) ? fhkp_pkg::CHAR_LA : fhkp_pkg::CHAR_UA) + v - 10);
	endfunction

	function void push_hex_bytes(input int n, input int line_len, input logic noisy);
		int col_n;
		col_n = 0;
		for (int k = 0; k < 2 * n; k++) begin
			if (noisy && $urandom_range(9) == 0)
				text_q.push_back(BLANKS[$urandom_range(4)]);
			if (noisy && $urandom_range(79) == 0)
				text_q.push_back(8'($urandom_range(255)));
			text_q.push_back(rand_hex_char());
			col_n++;
			if (col_n >= line_len) begin
				text_q.push_back(fhkp_pkg::CHAR_NL);
				col_n = 0;
			end
		end
		if (noisy && $urandom_range(7) == 0)
			text_q.push_back(rand_hex_char());
		if (text_q.size() == 0 || text_q[$] != fhkp_pkg::CHAR_NL)
			text_q.push_back(fhkp_pkg::CHAR_NL);
	endfunction

	function void build_random_text();
		int nb;
		int fsel;
		if ($urandom_range(99) < 75) begin
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(10))
					text_q.push_back(8'($urandom_range(255)));
				text_q.push_back(fhkp_pkg::CHAR_NL);
			end
			push_frame(1'b1,
				($urandom_range(9) == 0) ? int'($urandom_range(fhkp_pkg::HEAD_LEN - 1)) : -1);
			text_q.push_back(fhkp_pkg::CHAR_NL);
			nb = ($urandom_range(19) == 0) ? $urandom_range(KEY_BYTES + 8, KEY_BYTES)
				: $urandom_range(12);
			push_hex_bytes(nb, ($urandom_range(3) == 0) ? 100000 : $urandom_range(64, 2), 1'b1);
			fsel = $urandom_range(9);
			if (fsel == 1)
				push_frame(1'b0, $urandom_range(fhkp_pkg::FOOT_LEN - 1));
			else if (fsel > 1)
				push_frame(1'b0, -1);
			if (fsel != 0 && $urandom_range(1))
				text_q.push_back(fhkp_pkg::CHAR_NL);
			if ($urandom_range(7) == 0)
				text_q.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(24, 1)) begin
				case ($urandom_range(3))
					0: text_q.push_back(fhkp_pkg::CHAR_NL);
					1: text_q.push_back(fhkp_pkg::CHAR_DASH);
					default: text_q.push_back(8'($urandom_range(255)));
				endcase
			end
		end
	endfunction

	task automatic test_extremes();
		write_must_succeed(1'b0);
		text_q = '{8'h00, 8'hFF};
		send_text();
		text_q = '{fhkp_pkg::CHAR_NL, 8'h7F};
		send_text();
		wait_idle();
	endtask

	task automatic test_header_data();
		push_frame(1'b1, -1);
		text_q.push_back(fhkp_pkg::CHAR_NL);
		push_str("0aF9 Bc");
		text_q.push_back(fhkp_pkg::CHAR_HT);
		text_q.push_back(fhkp_pkg::CHAR_VT);
		text_q.push_back(fhkp_pkg::CHAR_FF);
		text_q.push_back(fhkp_pkg::CHAR_CR);
		text_q.push_back(fhkp_pkg::CHAR_NL);
		push_str("9e g 7");
		send_text();
		wait_idle();
	endtask

	task automatic test_must_succeed();
		write_must_succeed(1'b1);
		push_str("x");
		send_text();
		push_frame(1'b1, -1);
		text_q.push_back(fhkp_pkg::CHAR_NL);
		push_str("ab");
		text_q.push_back(fhkp_pkg::CHAR_NL);
		push_frame(1'b0, -1);
		send_text();
		wait_idle();
	endtask

	// One long data line: the dash lands past the saturated column, then the store overflows
	task automatic test_full_store();
		push_frame(1'b1, -1);
		text_q.push_back(fhkp_pkg::CHAR_NL);
		repeat (STORE_BYTES) text_q.push_back(rand_hex_char());
		text_q.push_back(fhkp_pkg::CHAR_DASH);
		repeat (STORE_BYTES + 8) text_q.push_back(rand_hex_char());
		push_str("zz");
		text_q.push_back(fhkp_pkg::CHAR_NL);
		push_frame(1'b0, -1);
		text_q.push_back(fhkp_pkg::CHAR_NL);
		send_text();
		wait_idle();
	endtask

	task automatic test_backpressure();
		push_hex_bytes(8, 6, 1'b0);
		hold_left = 60;
		send_text();
		wait_idle();
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		int start;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(5) == 0) begin
				wait_idle();
				write_must_succeed($urandom_range(1));
			end
			build_random_text();
			send_text();
		end
		wait_idle();
	endtask

	initial begin
		arst_n         = 1'b0;
		char_valid     = 1'b0;
		char_item      = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		must_succeed_q = 1'b0;
		errors         = 0;
		items_sent     = 0;
		results_seen   = 0;
		texts_sent     = 0;
		bytes_decoded  = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 0;
		clear_parse();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 17;
		recv_stall_pct = 68;
		test_extremes();
		test_header_data();
		test_must_succeed();
		test_random_traffic(17, 68);
		test_random_traffic(68, 17);
		test_full_store();
		test_random_traffic(0, 0);
		test_backpressure();

		wait_idle();
		if (expected_res.size() != 0)
			errors++;
		$display("Checked %0d results from %0d texts, %0d characters, %0d key bytes decoded.",
			results_seen, texts_sent, items_sent, bytes_decoded);
		$display("Covered framing, bad characters, a full store on an overlong line,");
		$display("both modes, idling on either side and a long receiver hold-off.");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fhkp_pkg.sv
rtl/fhkp_parse.sv
rtl/framed_hex_key_parser.sv
tb/sv/framed_hex_key_parser_tb.sv
